// ----- sv/dcie_pkg.sv -----
// ----------------------------------------------------------------------------
// dcie_pkg
// Shared types and constants for the call-frame CIE header parser.
// ----------------------------------------------------------------------------
package dcie_pkg;

    // Parser phase, one per header field
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LEN,
        PH_EXTLEN,
        PH_ID,
        PH_VER,
        PH_AUG,
        PH_CALIGN,
        PH_DALIGN,
        PH_RETREG,
        PH_AUGLEN,
        PH_SKIP
    } t_phase;

    // Result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_EXT_BIG  = 3'd1;
    localparam t_status ST_BAD_ID   = 3'd2;
    localparam t_status ST_BAD_VER  = 3'd3;
    localparam t_status ST_EH_AUG   = 3'd4;
    localparam t_status ST_OVERRUN  = 3'd5;

    // Field constants
    localparam logic [31:0] LEN_ESCAPE    = 32'hffff_ffff;
    localparam logic [7:0]  CIE_VERSION   = 8'd1;
    localparam logic [7:0]  CH_Z          = 8'h7a;
    localparam logic [7:0]  CH_E          = 8'h65;
    localparam logic [7:0]  CH_H          = 8'h68;
    localparam logic [5:0]  LEB_STEP      = 6'd7;
    localparam logic [5:0]  LEB_SHIFT_MAX = 6'd35;
    localparam logic [5:0]  LEB_SIGN_MAX  = 6'd21;
    localparam logic [32:0] CNT_MAX       = 33'h1_ffff_ffff;

    // Result payload width: 129 bits of fields padded to whole bytes
    localparam int unsigned OUT_DATA_W = 136;

endpackage

// ----- sv/dwarf_cie_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// dwarf_cie_header_parser_top
// Byte-stream parser for call-frame CIE headers, one result per record.
// ----------------------------------------------------------------------------
// The parser takes one record byte per clock cycle unless stalled, and the
// result of a record leaves through an output register in the cycle after the
// byte that ends the record or raises its first error. Each byte passes once
// through the phase logic (field assembly, LEB128 group merge, length count)
// between the parser state registers and the result register; the input side
// keeps accepting in the cycle that a held result is taken, and stalls only
// when the result register is still full and the sink is not ready. A byte
// with the start flag set begins a new record and drops any record in
// progress; bytes seen while idle without the start flag are discarded.
// ----------------------------------------------------------------------------
module dwarf_cie_header_parser_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Byte stream in
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] data_byte
    input  logic         i_s_tuser,   // [0] record_start
    // Header result out
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] code_align, [63:32] data_align, [64] has_aug_data,
    // [96:65] aug_data_length, [128:97] record_length, [135:129] zero
    output logic [dcie_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [2:0]   o_m_tuser    // [2:0] status
);

    // Parser state
    dcie_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_idx, n_idx;
    logic [63:0]      r_acc, n_acc;
    logic [5:0]       r_shift, n_shift;
    logic [31:0]      r_len, n_len;
    logic [32:0]      r_cnt, n_cnt;
    logic             r_saw_z, n_saw_z;
    logic             r_prev_e, n_prev_e;
    logic [31:0]      r_code, n_code;
    logic [31:0]      r_data, n_data;
    logic [31:0]      r_aug, n_aug;
    logic [31:0]      r_skip, n_skip;
    logic             n_emit;
    dcie_pkg::t_status n_status;

    // Result register
    logic                           r_out_valid;
    logic [dcie_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [2:0]                     r_out_status;

    logic        w_in_accept;
    logic [7:0]  w_byte;
    logic        w_leb_last;
    logic [31:0] w_leb_add;
    logic [31:0] w_leb_val;
    logic [5:0]  w_leb_nshift;
    logic [31:0] w_sign_fill;

    assign w_byte      = i_s_tdata;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_in_accept = i_s_tvalid && o_s_tready;

    // Merge one LEB128 group; groups at bit 32 and above drop out
    assign w_leb_last   = !w_byte[7];
    assign w_leb_add    = (r_shift < 6'd32) ? (32'(w_byte[6:0]) << r_shift) : 32'd0;
    assign w_leb_val    = r_acc[31:0] | w_leb_add;
    assign w_leb_nshift = (r_shift < dcie_pkg::LEB_SHIFT_MAX) ?
                          6'(r_shift + dcie_pkg::LEB_STEP) : r_shift;
    assign w_sign_fill  = (w_byte[6] && (r_shift <= dcie_pkg::LEB_SIGN_MAX)) ?
                          (32'hffff_ffff << 6'(r_shift + dcie_pkg::LEB_STEP)) : 32'd0;

    // Next parser state and result for the byte at the input
    always_comb begin
        logic [63:0]       v_acc;
        logic [31:0]       v_word;
        dcie_pkg::t_phase  v_phase;
        dcie_pkg::t_status v_fin;

        n_phase  = r_phase;
        n_idx    = r_idx;
        n_acc    = r_acc;
        n_shift  = r_shift;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_saw_z  = r_saw_z;
        n_prev_e = r_prev_e;
        n_code   = r_code;
        n_data   = r_data;
        n_aug    = r_aug;
        n_skip   = r_skip;
        n_emit   = 1'b0;
        n_status = dcie_pkg::ST_OK;
        v_acc    = r_acc;
        v_word   = r_acc[31:0];
        v_fin    = dcie_pkg::ST_OK;

        // Start flag: drop any record in progress and begin afresh
        if (i_s_tuser) begin
            n_phase  = dcie_pkg::PH_LEN;
            n_idx    = 3'd0;
            n_acc    = 64'd0;
            n_shift  = 6'd0;
            n_len    = 32'd0;
            n_cnt    = 33'd0;
            n_saw_z  = 1'b0;
            n_prev_e = 1'b0;
            n_code   = 32'd0;
            n_data   = 32'd0;
            n_aug    = 32'd0;
            n_skip   = 32'd0;
        end
        v_phase = n_phase;

        if (v_phase != dcie_pkg::PH_IDLE) begin
            // Count bytes after the length field, saturating
            if (v_phase != dcie_pkg::PH_LEN && v_phase != dcie_pkg::PH_EXTLEN &&
                n_cnt != dcie_pkg::CNT_MAX) begin
                n_cnt = n_cnt + 33'd1;
            end
            v_fin = (n_cnt > {1'b0, n_len}) ? dcie_pkg::ST_OVERRUN : dcie_pkg::ST_OK;

            unique case (v_phase)
                dcie_pkg::PH_LEN, dcie_pkg::PH_ID: begin
                    v_acc = n_acc;
                    v_acc[{n_idx[1:0], 3'b000} +: 8] =
                        v_acc[{n_idx[1:0], 3'b000} +: 8] | w_byte;
                    v_word = v_acc[31:0];
                    n_idx  = n_idx + 3'd1;
                    if (n_idx == 3'd4) begin
                        n_acc = 64'd0;
                        n_idx = 3'd0;
                        if (v_phase == dcie_pkg::PH_ID) begin
                            if (v_word != 32'd0) begin
                                n_emit   = 1'b1;
                                n_status = dcie_pkg::ST_BAD_ID;
                                n_phase  = dcie_pkg::PH_IDLE;
                            end else begin
                                n_phase = dcie_pkg::PH_VER;
                            end
                        end else if (v_word == dcie_pkg::LEN_ESCAPE) begin
                            n_phase = dcie_pkg::PH_EXTLEN;
                        end else begin
                            n_len   = v_word;
                            n_phase = dcie_pkg::PH_ID;
                        end
                    end else begin
                        n_acc = v_acc;
                    end
                end
                dcie_pkg::PH_EXTLEN: begin
                    v_acc = n_acc;
                    v_acc[{n_idx, 3'b000} +: 8] = v_acc[{n_idx, 3'b000} +: 8] | w_byte;
                    if (n_idx == 3'd7) begin
                        n_acc = 64'd0;
                        n_idx = 3'd0;
                        if (v_acc[63:32] != 32'd0) begin
                            n_emit   = 1'b1;
                            n_status = dcie_pkg::ST_EXT_BIG;
                            n_phase  = dcie_pkg::PH_IDLE;
                        end else begin
                            n_len   = v_acc[31:0];
                            n_phase = dcie_pkg::PH_ID;
                        end
                    end else begin
                        n_acc = v_acc;
                        n_idx = n_idx + 3'd1;
                    end
                end
                dcie_pkg::PH_VER: begin
                    if (w_byte != dcie_pkg::CIE_VERSION) begin
                        n_emit   = 1'b1;
                        n_status = dcie_pkg::ST_BAD_VER;
                        n_phase  = dcie_pkg::PH_IDLE;
                    end else begin
                        n_prev_e = 1'b0;
                        n_phase  = dcie_pkg::PH_AUG;
                    end
                end
                dcie_pkg::PH_AUG: begin
                    if (w_byte == 8'd0) begin
                        n_acc   = 64'd0;
                        n_shift = 6'd0;
                        n_phase = dcie_pkg::PH_CALIGN;
                    end else if (r_prev_e && w_byte == dcie_pkg::CH_H) begin
                        n_emit   = 1'b1;
                        n_status = dcie_pkg::ST_EH_AUG;
                        n_phase  = dcie_pkg::PH_IDLE;
                    end else begin
                        if (w_byte == dcie_pkg::CH_Z) begin
                            n_saw_z = 1'b1;
                        end
                        n_prev_e = (w_byte == dcie_pkg::CH_E);
                    end
                end
                dcie_pkg::PH_CALIGN: begin
                    if (w_leb_last) begin
                        n_code  = w_leb_val;
                        n_acc   = 64'd0;
                        n_shift = 6'd0;
                        n_phase = dcie_pkg::PH_DALIGN;
                    end else begin
                        n_acc   = {32'd0, w_leb_val};
                        n_shift = w_leb_nshift;
                    end
                end
                dcie_pkg::PH_DALIGN: begin
                    if (w_leb_last) begin
                        n_data  = w_leb_val | w_sign_fill;
                        n_acc   = 64'd0;
                        n_shift = 6'd0;
                        n_phase = dcie_pkg::PH_RETREG;
                    end else begin
                        n_acc   = {32'd0, w_leb_val};
                        n_shift = w_leb_nshift;
                    end
                end
                dcie_pkg::PH_RETREG: begin
                    if (!r_saw_z) begin
                        n_emit   = 1'b1;
                        n_status = v_fin;
                        n_phase  = dcie_pkg::PH_IDLE;
                    end else begin
                        n_acc   = 64'd0;
                        n_shift = 6'd0;
                        n_phase = dcie_pkg::PH_AUGLEN;
                    end
                end
                dcie_pkg::PH_AUGLEN: begin
                    if (w_leb_last) begin
                        n_aug   = w_leb_val;
                        n_skip  = w_leb_val;
                        n_acc   = 64'd0;
                        n_shift = 6'd0;
                        if (w_leb_val == 32'd0) begin
                            n_emit   = 1'b1;
                            n_status = v_fin;
                            n_phase  = dcie_pkg::PH_IDLE;
                        end else begin
                            n_phase = dcie_pkg::PH_SKIP;
                        end
                    end else begin
                        n_acc   = {32'd0, w_leb_val};
                        n_shift = w_leb_nshift;
                    end
                end
                dcie_pkg::PH_SKIP: begin
                    n_skip = r_skip - 32'd1;
                    if (n_skip == 32'd0) begin
                        n_emit   = 1'b1;
                        n_status = v_fin;
                        n_phase  = dcie_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = dcie_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Advance parser state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dcie_pkg::PH_IDLE;
            r_idx   <= 3'd0;
            r_shift <= 6'd0;
        end else if (w_in_accept) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_shift <= n_shift;
        end
    end

    // Hold datapath state; a start byte clears it
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_acc    <= n_acc;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_saw_z  <= n_saw_z;
            r_prev_e <= n_prev_e;
            r_code   <= n_code;
            r_data   <= n_data;
            r_aug    <= n_aug;
            r_skip   <= n_skip;
        end
    end

    // Result register: load on a finished record, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && n_emit) begin
            r_out_data   <= {7'd0, n_len, n_aug, n_saw_z, n_data, n_code};
            r_out_status <= n_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

    // A new result appears only after an accepted byte
    a_result_from_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_in_accept))
        else $error("result appeared without an accepted byte");

    // Every result leaves the parser idle
    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && n_emit) |=> (r_phase == dcie_pkg::PH_IDLE))
        else $error("parser not idle after a result");

    // LEB128 shift saturates at its ceiling
    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift <= dcie_pkg::LEB_SHIFT_MAX)
        else $error("LEB128 shift out of range");

    // Four-byte fields never index past their last byte
    a_word_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dcie_pkg::PH_LEN || r_phase == dcie_pkg::PH_ID) |-> (r_idx < 3'd4))
        else $error("word byte index out of range");

endmodule
